>>> src/crcfe_pkg.sv
// Shared types, constants and the CRC-32 byte update for the frame encoder.
`default_nettype none
package crcfe_pkg;

  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  // size + 6 = payload_len + 7
  localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
  localparam int          CMD_DEPTH      = 4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  typedef enum logic [1:0] {
    FM_IDLE = 2'd0,
    FM_SEND = 2'd1,
    FM_DROP = 2'd2
  } fmode_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_SZH,
    PH_SZL,
    PH_CODE,
    PH_DATA,
    PH_C3,
    PH_C2,
    PH_C1,
    PH_C0
  } phase_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  resp_code;
    logic [15:0] payload_len;
    logic [15:0] free_space;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
  } out_item_t;

  // One queued command: header bytes and/or one payload byte, optionally the CRC tail.
  typedef struct packed {
    logic        has_hdr;
    logic        has_data;
    logic        has_crc;
    logic [15:0] size;
    logic [7:0]  code;
    logic [7:0]  data;
    logic [31:0] crc;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/crcfe_front.sv
// Front end: accepts requests, tracks frame state and CRC, queues output commands.
`default_nettype none
module crcfe_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire crcfe_pkg::in_item_t in_item,
  output logic                    cmd_push,
  input  wire logic               cmd_full,
  output crcfe_pkg::cmd_t         cmd
);

  crcfe_pkg::fmode_t mode_r, mode_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [31:0]       crc_r, crc_nxt;

  logic        accept;
  logic [16:0] need;
  logic        drop;
  logic        len_zero;
  logic [15:0] size;
  logic [15:0] left_dec;
  logic [31:0] crc_code;
  logic [31:0] crc_data;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign need     = {1'b0, in_item.payload_len} + crcfe_pkg::FRAME_OVERHEAD;
  assign drop     = need[16] || ({1'b0, in_item.free_space} < need);
  assign len_zero = (in_item.payload_len == 16'd0);
  assign size     = in_item.payload_len + 16'd1;
  assign left_dec = left_r - 16'd1;
  assign crc_code = crcfe_pkg::crc_byte(crcfe_pkg::CRC_INIT, in_item.resp_code);
  assign crc_data = crcfe_pkg::crc_byte(crc_r, in_item.data_byte);

  always_comb begin : next_state
    mode_nxt = mode_r;
    left_nxt = left_r;
    crc_nxt  = crc_r;
    if (accept) begin
      if (in_item.req_type == crcfe_pkg::REQ_START) begin
        left_nxt = in_item.payload_len;
        crc_nxt  = crcfe_pkg::CRC_INIT;
        if (drop) begin
          mode_nxt = len_zero ? crcfe_pkg::FM_IDLE : crcfe_pkg::FM_DROP;
        end else if (len_zero) begin
          mode_nxt = crcfe_pkg::FM_IDLE;
        end else begin
          mode_nxt = crcfe_pkg::FM_SEND;
          crc_nxt  = crc_code;
        end
      end else begin
        unique case (mode_r)
          crcfe_pkg::FM_SEND: begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              mode_nxt = crcfe_pkg::FM_IDLE;
              crc_nxt  = crcfe_pkg::CRC_INIT;
            end else begin
              crc_nxt = crc_data;
            end
          end
          crcfe_pkg::FM_DROP: begin
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              mode_nxt = crcfe_pkg::FM_IDLE;
            end
          end
          default: begin
            // data while idle is ignored
          end
        endcase
      end
    end
  end

  always_comb begin : outputs
    cmd_push     = 1'b0;
    cmd.has_hdr  = 1'b0;
    cmd.has_data = 1'b0;
    cmd.has_crc  = 1'b0;
    cmd.size     = size;
    cmd.code     = in_item.resp_code;
    cmd.data     = in_item.data_byte;
    cmd.crc      = ~crc_data;
    if (accept) begin
      if (in_item.req_type == crcfe_pkg::REQ_START) begin
        cmd.crc = ~crc_code;
        if (!drop) begin
          cmd_push    = 1'b1;
          cmd.has_hdr = 1'b1;
          cmd.has_crc = len_zero;
        end
      end else if (mode_r == crcfe_pkg::FM_SEND) begin
        cmd_push     = 1'b1;
        cmd.has_data = 1'b1;
        cmd.has_crc  = (left_dec == 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= crcfe_pkg::FM_IDLE;
      left_r <= 16'd0;
      crc_r  <= crcfe_pkg::CRC_INIT;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // a frame being sent always has payload bytes outstanding
  a_send_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == crcfe_pkg::FM_SEND |-> left_r != 16'd0)
    else $error("send mode with no bytes left");

endmodule
`default_nettype wire

>>> src/crcfe_cmd_fifo.sv
// Short command queue between the front end and the byte sequencer.
`default_nettype none
module crcfe_cmd_fifo #(
  parameter int DEPTH = crcfe_pkg::CMD_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire crcfe_pkg::cmd_t wr_cmd,
  output logic                 full,
  input  wire logic            pop,
  output crcfe_pkg::cmd_t      head,
  output logic                 empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  crcfe_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("command queue count overflow");

endmodule
`default_nettype wire

>>> src/crcfe_back.sv
// Back end: commands to bytes, one per cycle while the output drains.
`default_nettype none
module crcfe_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire crcfe_pkg::cmd_t head,
  input  wire logic            fifo_empty,
  output logic                 fifo_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output crcfe_pkg::out_item_t out_item
);

  crcfe_pkg::phase_t    phase_r, phase_nxt;
  crcfe_pkg::phase_t    cur;
  crcfe_pkg::phase_t    step_nxt;
  crcfe_pkg::out_item_t out_r;
  crcfe_pkg::out_item_t byte_sel;
  logic                 out_valid_r;
  logic                 can_load;
  logic                 fire;

  assign can_load  = !out_valid_r || out_pop;
  assign fire      = !fifo_empty && can_load;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  // PH_START means the head command has not been started yet
  assign cur = (phase_r != crcfe_pkg::PH_START) ? phase_r :
               (head.has_hdr ? crcfe_pkg::PH_SZH : crcfe_pkg::PH_DATA);

  always_comb begin : next_state
    unique case (cur)
      crcfe_pkg::PH_SZH:  step_nxt = crcfe_pkg::PH_SZL;
      crcfe_pkg::PH_SZL:  step_nxt = crcfe_pkg::PH_CODE;
      crcfe_pkg::PH_CODE: step_nxt = head.has_crc ? crcfe_pkg::PH_C3 : crcfe_pkg::PH_START;
      crcfe_pkg::PH_DATA: step_nxt = head.has_crc ? crcfe_pkg::PH_C3 : crcfe_pkg::PH_START;
      crcfe_pkg::PH_C3:   step_nxt = crcfe_pkg::PH_C2;
      crcfe_pkg::PH_C2:   step_nxt = crcfe_pkg::PH_C1;
      crcfe_pkg::PH_C1:   step_nxt = crcfe_pkg::PH_C0;
      default:            step_nxt = crcfe_pkg::PH_START;
    endcase
    phase_nxt = fire ? step_nxt : phase_r;
  end

  always_comb begin : outputs
    fifo_pop            = fire && (step_nxt == crcfe_pkg::PH_START);
    byte_sel.frame_last = (cur == crcfe_pkg::PH_C0);
    unique case (cur)
      crcfe_pkg::PH_SZH:  byte_sel.out_byte = head.size[15:8];
      crcfe_pkg::PH_SZL:  byte_sel.out_byte = head.size[7:0];
      crcfe_pkg::PH_CODE: byte_sel.out_byte = head.code;
      crcfe_pkg::PH_DATA: byte_sel.out_byte = head.data;
      crcfe_pkg::PH_C3:   byte_sel.out_byte = head.crc[31:24];
      crcfe_pkg::PH_C2:   byte_sel.out_byte = head.crc[23:16];
      crcfe_pkg::PH_C1:   byte_sel.out_byte = head.crc[15:8];
      crcfe_pkg::PH_C0:   byte_sel.out_byte = head.crc[7:0];
      default:            byte_sel.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crcfe_pkg::PH_START;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= byte_sel;
    end
  end

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("command popped from empty queue");

  a_mid_cmd_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != crcfe_pkg::PH_START |-> !fifo_empty)
    else $error("command in progress without queued head");

  a_last_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cur == crcfe_pkg::PH_C0 |=> out_valid_r && out_item.frame_last)
    else $error("final CRC byte not flagged");

endmodule
`default_nettype wire

>>> src/crc32_frame_encoder.sv
// Top level of the length-prefixed CRC-32 frame encoder.
//
// Requests enter through a queue-style port: in_item is taken at a rising
// edge with in_push high and in_full low. A start request opens a frame;
// data requests carry one payload byte each. Output bytes leave through a
// queue-style port: out_item holds the oldest byte while out_empty is low
// and is taken at an edge with out_pop high.
// Frame: size (payload_len + 1) MSB first, code, payload, CRC-32 MSB first;
// frame_last marks the last CRC byte. Frames that do not fit are dropped.
// A request's first byte passes the command queue and output register.
// Throughput: one data request per cycle while the receiver keeps up, except
// the one that ends a frame (5 bytes: payload byte plus CRC); a start request
// gives 3 bytes (7 with an empty payload), absorbed by the command queue of
// CMD_DEPTH entries. The single-byte output register sets the rate.
// When the receiver stalls the queue fills and in_full rises; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and output, frame idle.
`default_nettype none
module crc32_frame_encoder #(
  parameter int CMD_DEPTH = crcfe_pkg::CMD_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire crcfe_pkg::in_item_t in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output crcfe_pkg::out_item_t     out_item
);

  crcfe_pkg::cmd_t wr_cmd;
  crcfe_pkg::cmd_t head;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            cmd_empty;

  crcfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd      (wr_cmd)
  );

  crcfe_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (wr_cmd),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .head   (head),
    .empty  (cmd_empty)
  );

  crcfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_empty (cmd_empty),
    .fifo_pop   (cmd_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the length-prefixed CRC-32 frame encoder.
`default_nettype none
module tb_top;
  import crcfe_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN       = 40;
  localparam int          RAND_ITEMS  = 150;
  localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_REFL    = 32'hEDB8_8320;
  localparam logic [16:0] LIMIT_16    = 17'h0_FFFF;

  // Predicts the framed byte stream and checks the bytes that come out.
  class frame_scoreboard;
    out_item_t   exp_bytes[$];
    logic [31:0] crc_run;
    logic [15:0] remaining;
    fmode_t      mode;
    int          errors;

    function new();
      crc_run   = CRC_SEED;
      remaining = 16'd0;
      mode      = FM_IDLE;
      errors    = 0;
    endfunction

    // bit-serial form of the reflected update, LSB first
    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r  = {1'b0, r[31:1]};
        if (fb) r = r ^ CRC_REFL;
      end
      return r;
    endfunction

    function void emit(logic [7:0] b, logic last);
      out_item_t e;
      e.out_byte   = b;
      e.frame_last = last;
      exp_bytes.push_back(e);
    endfunction

    function void emit_crc();
      logic [31:0] c;
      c = ~crc_run;
      emit(c[31:24], 1'b0);
      emit(c[23:16], 1'b0);
      emit(c[15:8], 1'b0);
      emit(c[7:0], 1'b1);
      crc_run = CRC_SEED;
      mode    = FM_IDLE;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_request(in_item_t it);
      logic [15:0] size;
      logic [16:0] need;
      if (it.req_type == REQ_START) begin
        size      = it.payload_len + 16'd1;
        need      = {1'b0, it.payload_len} + 17'd7;
        crc_run   = CRC_SEED;
        remaining = it.payload_len;
        if (need > LIMIT_16 || {1'b0, it.free_space} < need) begin
          mode = (it.payload_len != 16'd0) ? FM_DROP : FM_IDLE;
          return;
        end
        emit(size[15:8], 1'b0);
        emit(size[7:0], 1'b0);
        crc_run = crc_next(crc_run, it.resp_code);
        emit(it.resp_code, 1'b0);
        if (it.payload_len == 16'd0) emit_crc();
        else mode = FM_SEND;
      end else if (mode == FM_SEND) begin
        crc_run = crc_next(crc_run, it.data_byte);
        emit(it.data_byte, 1'b0);
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) emit_crc();
      end else if (mode == FM_DROP) begin
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) mode = FM_IDLE;
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t e;
      if (exp_bytes.size() == 0) begin
        flag($sformatf("unexpected byte %02h last %0b", got.out_byte, got.frame_last));
        return;
      end
      e = exp_bytes.pop_front();
      if (got.out_byte !== e.out_byte || got.frame_last !== e.frame_last)
        flag($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                       e.out_byte, e.frame_last, got.out_byte, got.frame_last));
    endfunction

    function int pending();
      return exp_bytes.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  int              cycles = 0;
  frame_scoreboard sb;
  in_item_t        req_list[$];

  crc32_frame_encoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random gap before the next transfer, with occasional back-to-back stretches.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 32);
    return $urandom_range(0, 15);
  endfunction

  function automatic in_item_t mk_start(logic [7:0] code, logic [15:0] len,
                                        logic [15:0] space);
    in_item_t it;
    it.req_type    = REQ_START;
    it.resp_code   = code;
    it.payload_len = len;
    it.free_space  = space;
    it.data_byte   = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_data(logic [7:0] b);
    in_item_t it;
    it.req_type    = REQ_DATA;
    it.resp_code   = 8'($urandom);
    it.payload_len = 16'($urandom);
    it.free_space  = 16'($urandom);
    it.data_byte   = b;
    return it;
  endfunction

  task automatic build_directed();
    req_list.push_back(mk_data(8'hFF));                     // data while idle
    req_list.push_back(mk_start(8'h00, 16'd0, 16'hFFFF));   // empty payload
    req_list.push_back(mk_start(8'hFF, 16'd0, 16'd7));      // fits exactly
    req_list.push_back(mk_start(8'h11, 16'd0, 16'd6));      // one byte short
    req_list.push_back(mk_data(8'h00));
    req_list.push_back(mk_start(8'hA5, 16'd3, 16'd10));
    req_list.push_back(mk_data(8'h00));
    req_list.push_back(mk_data(8'hFF));
    req_list.push_back(mk_data(8'h5A));
    req_list.push_back(mk_start(8'h42, 16'd2, 16'd8));      // not enough space
    req_list.push_back(mk_data(8'h12));
    req_list.push_back(mk_data(8'h34));
    req_list.push_back(mk_data(8'h56));                     // back to idle
    // largest frame that fits, abandoned by a new start
    req_list.push_back(mk_start(8'hC3, 16'd65528, 16'hFFFF));
    for (int i = 0; i < 4; i++) req_list.push_back(mk_data(8'($urandom)));
    req_list.push_back(mk_start(8'h7E, 16'd1, 16'd100));
    req_list.push_back(mk_data(8'h3C));
    // too large for the 16-bit size check
    req_list.push_back(mk_start(8'h99, 16'd65529, 16'hFFFF));
    req_list.push_back(mk_data(8'hAA));
    req_list.push_back(mk_data(8'h55));
    req_list.push_back(mk_start(8'hFF, 16'hFFFF, 16'hFFFF));
    req_list.push_back(mk_start(8'h01, 16'd1, 16'hFFFF));
    req_list.push_back(mk_data(8'h80));
  endtask

  task automatic build_random();
    int          count;
    int unsigned r;
    int unsigned len;
    int unsigned nd;
    logic [15:0] space;
    count = 0;
    while (count < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        req_list.push_back(mk_data(8'($urandom)));
        count++;
      end else if (r < 14) begin
        // oversized or random-length start, a few bytes, then cut short
        len   = ($urandom_range(0, 1) == 1) ? $urandom_range(65520, 65535) : $urandom;
        space = 16'($urandom);
        req_list.push_back(mk_start(8'($urandom), 16'(len), space));
        nd = $urandom_range(0, 4);
        for (int i = 0; i < nd; i++) req_list.push_back(mk_data(8'($urandom)));
        count += nd + 1;
      end else begin
        len = $urandom_range(0, 12);
        if ($urandom_range(0, 4) != 0) space = 16'($urandom_range(len + 7, 65535));
        else space = 16'($urandom_range(0, len + 6));
        req_list.push_back(mk_start(8'($urandom), 16'(len), space));
        nd = len;
        if (len > 0 && $urandom_range(0, 9) == 0) nd = $urandom_range(0, len - 1);
        for (int i = 0; i < nd; i++) req_list.push_back(mk_data(8'($urandom)));
        count += nd + 1;
      end
    end
  endtask

  task automatic push_request(input in_item_t it, inout int burst);
    int gap;
    gap = draw_gap(burst);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic drain_bytes();
    int gap;
    int burst;
    burst = 0;
    forever begin
      gap = draw_gap(burst);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      sb.check_byte(out_item);
    end
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    drain_bytes();
  end

  initial begin
    int burst;
    burst = 0;
    sb = new();
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (req_list[i]) push_request(req_list[i], burst);
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
